// ===== hw/rtl/hrol_pkg.sv =====
// Shared constants, codes and types of the hash ring owner lookup.
package hrol_pkg;

    localparam int RING_DEPTH = 64;
    localparam int SERVER_IDS = 256;
    localparam int POINT_W    = 64;
    localparam int ID_W       = 8;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PREV   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t CELL_HOLD    = 2'd0;
    localparam cell_op_t CELL_INSERT  = 2'd1;
    localparam cell_op_t CELL_REPLACE = 2'd2;
    localparam cell_op_t CELL_REMOVE  = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [POINT_W-1:0] point;
        logic [ID_W-1:0]    owner;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic ge;
        logic gt;
        logic eq;
        logic match;
    } cell_flags_t;

    typedef struct packed {
        cell_op_t op;
        logic     take_right;
    } cell_ctl_t;

    localparam entry_t HEAD_ENT  = '{valid: 1'b1, point: '0, owner: '0};
    localparam entry_t EMPTY_ENT = '{valid: 1'b0, point: '0, owner: '0};

endpackage

// ===== hw/rtl/hash_ring_owner_lookup.sv =====
// Top level of the hash ring owner lookup: sequencer, membership marks and chain of ring cells.
//
//   channel | signals                         | direction
//   input   | in_valid in_ready mode point     | transaction in
//           | server_id                        |
//   output  | out_valid out_ready owner_id     | transaction out
//           | status                           |
//
// Each item goes through accept, compare in every cell, then decide and update the cells.
// The next item is accepted in the cycle after the update.
// The decide step holds while an earlier result is still not taken by the output side.
// Reset clears the cell valid bits, the membership marks and the sequencer; no clearing pass.
module hash_ring_owner_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hrol_pkg::MODE_W-1:0]   mode,
    input  logic [hrol_pkg::POINT_W-1:0]  point,
    input  logic [hrol_pkg::ID_W-1:0]     server_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hrol_pkg::ID_W-1:0]     owner_id,
    output logic [hrol_pkg::STATUS_W-1:0] status
);

    localparam int DEPTH = hrol_pkg::RING_DEPTH;
    localparam int PRE_STEPS = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [hrol_pkg::MODE_W-1:0]         mode_reg;
    logic [hrol_pkg::POINT_W-1:0]        key_reg;
    logic [hrol_pkg::ID_W-1:0]           id_reg;
    logic [hrol_pkg::SERVER_IDS-1:0]     member_reg;
    logic [hrol_pkg::SERVER_IDS-1:0]     member_next;
    logic                                out_valid_reg;
    logic [hrol_pkg::ID_W-1:0]           owner_reg;
    logic [hrol_pkg::ID_W-1:0]           owner_next;
    logic [hrol_pkg::STATUS_W-1:0]       status_reg;
    logic [hrol_pkg::STATUS_W-1:0]       status_next;

    logic                                accept;
    logic                                exec_fire;
    logic                                cmp_en;
    logic                                is_member;
    hrol_pkg::cell_op_t                  op_sel;

    hrol_pkg::entry_t                    ent [DEPTH];
    hrol_pkg::cell_flags_t               flg [DEPTH];
    hrol_pkg::cell_ctl_t                 ctl [DEPTH];

    logic [DEPTH-1:0] v_vec;
    logic [DEPTH-1:0] ge_vec;
    logic [DEPTH-1:0] gt_vec;
    logic [DEPTH-1:0] eq_vec;
    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] first_ge;
    logic [DEPTH-1:0] tgt_vec;
    logic [DEPTH-1:0] last_v;
    logic [DEPTH-1:0] next_vec;
    logic [DEPTH-1:0] prev_vec;
    logic [DEPTH-1:0] sel_vec;
    logic [DEPTH-1:0] pre_vec;
    logic [hrol_pkg::ID_W-1:0] owner_sel;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cmp_en    = (state_reg == ST_CMP);
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign is_member = member_reg[id_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            hrol_pkg::entry_t left_ent;
            hrol_pkg::entry_t right_ent;
            logic             left_gt;

            if (gi == 0)
            begin : g_head
                assign left_ent = hrol_pkg::HEAD_ENT;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_body
                assign left_ent = ent[gi-1];
                assign left_gt  = flg[gi-1].gt;
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_ent = hrol_pkg::EMPTY_ENT;
            end
            else
            begin : g_inner
                assign right_ent = ent[gi+1];
            end

            assign ctl[gi].op         = exec_fire ? op_sel : hrol_pkg::CELL_HOLD;
            assign ctl[gi].take_right = pre_vec[gi];

            hrol_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmp_en    (cmp_en),
                .key       (key_reg),
                .id        (id_reg),
                .ctl       (ctl[gi]),
                .left_ent  (left_ent),
                .left_gt   (left_gt),
                .right_ent (right_ent),
                .ent       (ent[gi]),
                .flg       (flg[gi])
            );

            assign v_vec[gi]     = flg[gi].valid;
            assign ge_vec[gi]    = flg[gi].ge;
            assign gt_vec[gi]    = flg[gi].gt;
            assign eq_vec[gi]    = flg[gi].eq;
            assign match_vec[gi] = flg[gi].match;
        end
    endgenerate

    assign first_ge = ge_vec & ~(ge_vec << 1);
    assign tgt_vec  = (|ge_vec) ? first_ge : DEPTH'(1);
    assign last_v   = v_vec & ~(v_vec >> 1);

    always_comb
    begin
        next_vec    = (tgt_vec << 1) & v_vec;
        next_vec[0] = |(tgt_vec & last_v);
        prev_vec    = tgt_vec >> 1;
        if (tgt_vec[0])
        begin
            prev_vec = prev_vec | last_v;
        end
    end

    always_comb
    begin
        case (mode_reg)
            hrol_pkg::MODE_NEXT: sel_vec = next_vec;
            hrol_pkg::MODE_PREV: sel_vec = prev_vec;
            default:             sel_vec = tgt_vec;
        endcase
    end

    always_comb
    begin
        owner_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                owner_sel = owner_sel | ent[i].owner;
            end
        end
    end

    always_comb
    begin
        pre_vec = match_vec;
        for (int k = 0; k < PRE_STEPS; k++)
        begin
            pre_vec = pre_vec | (pre_vec << (1 << k));
        end
    end

    always_comb
    begin
        op_sel      = hrol_pkg::CELL_HOLD;
        member_next = member_reg;
        owner_next  = '0;
        status_next = hrol_pkg::STAT_OK;
        unique case (mode_reg) inside
            hrol_pkg::MODE_INSERT:
            begin
                if (is_member)
                begin
                    status_next = hrol_pkg::STAT_PRESENT;
                end
                else if (|eq_vec)
                begin
                    op_sel              = hrol_pkg::CELL_REPLACE;
                    member_next[id_reg] = 1'b1;
                end
                else if (v_vec[DEPTH-1])
                begin
                    status_next = hrol_pkg::STAT_FULL;
                end
                else
                begin
                    op_sel              = hrol_pkg::CELL_INSERT;
                    member_next[id_reg] = 1'b1;
                end
            end
            hrol_pkg::MODE_REMOVE:
            begin
                if (!is_member)
                begin
                    status_next = hrol_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    op_sel              = hrol_pkg::CELL_REMOVE;
                    member_next[id_reg] = 1'b0;
                end
            end
            hrol_pkg::MODE_LOOKUP, hrol_pkg::MODE_NEXT, hrol_pkg::MODE_PREV:
            begin
                if (!v_vec[0])
                begin
                    status_next = hrol_pkg::STAT_EMPTY;
                end
                else
                begin
                    owner_next = owner_sel;
                end
            end
            default:
            begin
                status_next = hrol_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            member_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                member_reg    <= member_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            key_reg  <= point;
            id_reg   <= server_id;
        end
        if (exec_fire)
        begin
            owner_reg  <= owner_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign owner_id  = owner_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((v_vec >> 1) & ~v_vec) == '0)
        else $error("ring entries do not form a prefix");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CMP))
        else $error("accepted transaction did not enter compare");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_EXEC))
        else $error("result raised outside execute");

    a_owner_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (owner_id != '0)) |-> (status == hrol_pkg::STAT_OK))
        else $error("nonzero owner with failing status");
`endif

endmodule

// ===== hw/rtl/hrol_cell.sv =====
// One ring cell: holds an entry, compares it with the key and shifts with its neighbors.
module hrol_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmp_en,
    input  logic [hrol_pkg::POINT_W-1:0] key,
    input  logic [hrol_pkg::ID_W-1:0]    id,
    input  hrol_pkg::cell_ctl_t          ctl,
    input  hrol_pkg::entry_t             left_ent,
    input  logic                         left_gt,
    input  hrol_pkg::entry_t             right_ent,
    output hrol_pkg::entry_t             ent,
    output hrol_pkg::cell_flags_t        flg
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [hrol_pkg::POINT_W-1:0] point_reg;
    logic [hrol_pkg::POINT_W-1:0] point_next;
    logic [hrol_pkg::ID_W-1:0]    owner_reg;
    logic [hrol_pkg::ID_W-1:0]    owner_next;
    hrol_pkg::cell_flags_t        flags_reg;
    hrol_pkg::cell_flags_t        flags_next;
    logic                         shift_in;

    always_comb
    begin
        flags_next       = flags_reg;
        flags_next.valid = valid_reg;
        if (cmp_en)
        begin
            flags_next.ge    = valid_reg && (point_reg >= key);
            flags_next.eq    = valid_reg && (point_reg == key);
            flags_next.gt    = valid_reg && (point_reg > key);
            flags_next.match = valid_reg && (owner_reg == id);
        end
    end

    assign shift_in = flags_reg.gt || (!valid_reg && left_ent.valid);

    always_comb
    begin
        valid_next = valid_reg;
        point_next = point_reg;
        owner_next = owner_reg;
        case (ctl.op)
            hrol_pkg::CELL_INSERT:
            begin
                if (shift_in)
                begin
                    valid_next = 1'b1;
                    if (left_gt)
                    begin
                        point_next = left_ent.point;
                        owner_next = left_ent.owner;
                    end
                    else
                    begin
                        point_next = key;
                        owner_next = id;
                    end
                end
            end
            hrol_pkg::CELL_REPLACE:
            begin
                if (flags_reg.eq)
                begin
                    owner_next = id;
                end
            end
            hrol_pkg::CELL_REMOVE:
            begin
                if (ctl.take_right)
                begin
                    valid_next = right_ent.valid;
                    point_next = right_ent.point;
                    owner_next = right_ent.owner;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
        owner_reg <= owner_next;
    end

    assign ent.valid = valid_reg;
    assign ent.point = point_reg;
    assign ent.owner = owner_reg;
    assign flg       = flags_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the hash ring owner lookup: ring predictor, traffic and checks.
module testbench;

    localparam int ITEM_TARGET  = 1900;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int POOL_SIZE    = 96;
    localparam int SMALL_IDS    = 72;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 300;

    localparam logic [hrol_pkg::POINT_W-1:0] POINT_MAX  = '1;
    localparam logic [hrol_pkg::POINT_W-1:0] POINT_HALF = 64'h8000_0000_0000_0000;
    localparam logic [hrol_pkg::POINT_W-1:0] POINT_ALT  = 64'h5555_5555_5555_5555;
    localparam logic [hrol_pkg::POINT_W-1:0] POOL_STEP  = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [hrol_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [hrol_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIX, PHASE_NOISE} phase_t;

    typedef struct packed {
        logic [hrol_pkg::ID_W-1:0]     owner;
        logic [hrol_pkg::STATUS_W-1:0] code;
    } reply_t;

    class ring_scoreboard;
        logic [hrol_pkg::POINT_W-1:0] ring_pt  [hrol_pkg::RING_DEPTH];
        logic [hrol_pkg::ID_W-1:0]    ring_own [hrol_pkg::RING_DEPTH];
        int                           used;
        bit                           member   [hrol_pkg::SERVER_IDS];
        reply_t                       expected_replies [$];
        int                           errors;
        int                           replies_seen;

        function new();
            used = 0;
            errors = 0;
            replies_seen = 0;
            foreach (member[i])
            begin
                member[i] = 1'b0;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_request(logic [hrol_pkg::MODE_W-1:0] m,
                                   logic [hrol_pkg::POINT_W-1:0] pt,
                                   logic [hrol_pkg::ID_W-1:0] id);
            reply_t rep;
            int     i;
            int     pos;
            int     hit;
            int     wr;
            int     slot;
            rep.owner = '0;
            rep.code  = hrol_pkg::STAT_OK;
            case (m)
                hrol_pkg::MODE_INSERT:
                begin
                    if (int'(id) >= hrol_pkg::SERVER_IDS)
                    begin
                        rep.code = hrol_pkg::STAT_NOT_FOUND;
                    end
                    else if (member[id])
                    begin
                        rep.code = hrol_pkg::STAT_PRESENT;
                    end
                    else
                    begin
                        pos = used;
                        hit = -1;
                        for (i = 0; i < used; i++)
                        begin
                            if (ring_pt[i] == pt)
                            begin
                                hit = i;
                                break;
                            end
                            if (ring_pt[i] > pt)
                            begin
                                pos = i;
                                break;
                            end
                        end
                        if (hit >= 0)
                        begin
                            ring_own[hit] = id;
                            member[id] = 1'b1;
                        end
                        else if (used >= hrol_pkg::RING_DEPTH)
                        begin
                            rep.code = hrol_pkg::STAT_FULL;
                        end
                        else
                        begin
                            for (i = used; i > pos; i--)
                            begin
                                ring_pt[i]  = ring_pt[i-1];
                                ring_own[i] = ring_own[i-1];
                            end
                            ring_pt[pos]  = pt;
                            ring_own[pos] = id;
                            used++;
                            member[id] = 1'b1;
                        end
                    end
                end
                hrol_pkg::MODE_REMOVE:
                begin
                    if (int'(id) >= hrol_pkg::SERVER_IDS || !member[id])
                    begin
                        rep.code = hrol_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        member[id] = 1'b0;
                        wr = 0;
                        for (i = 0; i < used; i++)
                        begin
                            if (ring_own[i] != id)
                            begin
                                ring_pt[wr]  = ring_pt[i];
                                ring_own[wr] = ring_own[i];
                                wr++;
                            end
                        end
                        used = wr;
                    end
                end
                hrol_pkg::MODE_LOOKUP, hrol_pkg::MODE_NEXT, hrol_pkg::MODE_PREV:
                begin
                    if (used == 0)
                    begin
                        rep.code = hrol_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        slot = 0;
                        for (i = used - 1; i >= 0; i--)
                        begin
                            if (ring_pt[i] >= pt)
                            begin
                                slot = i;
                            end
                        end
                        if (m == hrol_pkg::MODE_NEXT)
                        begin
                            slot = (slot + 1 < used) ? slot + 1 : 0;
                        end
                        else if (m == hrol_pkg::MODE_PREV)
                        begin
                            slot = (slot == 0) ? used - 1 : slot - 1;
                        end
                        rep.owner = ring_own[slot];
                    end
                end
                default:
                begin
                    rep.code = hrol_pkg::STAT_NOT_FOUND;
                end
            endcase
            expected_replies = {expected_replies, rep};
        endfunction

        function void check_reply(logic [hrol_pkg::ID_W-1:0] owner,
                                  logic [hrol_pkg::STATUS_W-1:0] code);
            reply_t want;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual owner_id %0d status %0d",
                         $time, owner, code);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (owner !== want.owner)
                begin
                    errors++;
                    $display("%0t: owner_id mismatch, expected %0d, actual %0d",
                             $time, want.owner, owner);
                end
                if (code !== want.code)
                begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.code, code);
                end
            end
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [hrol_pkg::MODE_W-1:0]   mode      = '0;
    logic [hrol_pkg::POINT_W-1:0]  point     = '0;
    logic [hrol_pkg::ID_W-1:0]     server_id = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [hrol_pkg::ID_W-1:0]     owner_id;
    logic [hrol_pkg::STATUS_W-1:0] status;

    ring_scoreboard sb = new();
    bit long_hold_done = 1'b0;

    hash_ring_owner_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .point     (point),
        .server_id (server_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .owner_id  (owner_id),
        .status    (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [hrol_pkg::MODE_W-1:0] m,
                             input logic [hrol_pkg::POINT_W-1:0] pt,
                             input logic [hrol_pkg::ID_W-1:0] id);
        mode      <= m;
        point     <= pt;
        server_id <= id;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(m, pt, id);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [hrol_pkg::POINT_W-1:0] pick_point();
        int                           roll;
        logic [hrol_pkg::POINT_W-1:0] base;
        roll = $urandom_range(0, 15);
        base = hrol_pkg::POINT_W'($urandom_range(0, POOL_SIZE - 1)) * POOL_STEP;
        case (roll)
            0, 1: return {$urandom, $urandom};
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 64'd1;
                    2: return POINT_MAX - 64'd1;
                    default: return POINT_MAX;
                endcase
            end
            3: return ($urandom_range(0, 1) == 1) ? base + 64'd1 : base - 64'd1;
            default: return base;
        endcase
    endfunction

    task automatic pick_transaction(input phase_t kind,
                                    output logic [hrol_pkg::MODE_W-1:0] m,
                                    output logic [hrol_pkg::POINT_W-1:0] pt,
                                    output logic [hrol_pkg::ID_W-1:0] id);
        int roll;
        int ins_pct;
        int rem_pct;
        int look_pct;
        int start;
        int k;
        case (kind)
            PHASE_FILL:
            begin
                ins_pct = 60;
                rem_pct = 10;
                look_pct = 25;
            end
            PHASE_DRAIN:
            begin
                ins_pct = 15;
                rem_pct = 50;
                look_pct = 30;
            end
            default:
            begin
                ins_pct = 30;
                rem_pct = 20;
                look_pct = 45;
            end
        endcase
        if (kind == PHASE_NOISE)
        begin
            m  = hrol_pkg::MODE_W'($urandom_range(0, 7));
            pt = {$urandom, $urandom};
            id = hrol_pkg::ID_W'($urandom_range(0, 255));
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                m = hrol_pkg::MODE_INSERT;
            else if (roll < ins_pct + rem_pct)
                m = hrol_pkg::MODE_REMOVE;
            else if (roll < ins_pct + rem_pct + look_pct)
                m = hrol_pkg::MODE_LOOKUP + hrol_pkg::MODE_W'($urandom_range(0, 2));
            else
                m = MODE_SPARE_LO + hrol_pkg::MODE_W'($urandom_range(0, 2));
            pt = pick_point();
            roll = $urandom_range(0, 3);
            if (roll == 0)
            begin
                id = hrol_pkg::ID_W'($urandom_range(0, 255));
            end
            else if (roll == 1 && m == hrol_pkg::MODE_REMOVE)
            begin
                start = $urandom_range(0, hrol_pkg::SERVER_IDS - 1);
                id = hrol_pkg::ID_W'(start);
                for (k = 0; k < hrol_pkg::SERVER_IDS; k++)
                begin
                    if (sb.member[(start + k) % hrol_pkg::SERVER_IDS])
                    begin
                        id = hrol_pkg::ID_W'((start + k) % hrol_pkg::SERVER_IDS);
                        break;
                    end
                end
            end
            else
            begin
                id = hrol_pkg::ID_W'($urandom_range(0, SMALL_IDS - 1));
            end
        end
    endtask

    task automatic run_phase(input phase_t kind, input int len);
        int                           burst;
        int                           k;
        logic [hrol_pkg::MODE_W-1:0]  m;
        logic [hrol_pkg::POINT_W-1:0] pt;
        logic [hrol_pkg::ID_W-1:0]    id;
        burst = $urandom_range(1, 24);
        for (k = 0; k < len; k++)
        begin
            pick_transaction(kind, m, pt, id);
            send_item(m, pt, id);
            burst--;
            if (burst == 0)
            begin
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic hold_ready(input logic level, input int cycles);
        out_ready <= level;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.replies_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_ready(1'b0, LONG_HOLD);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: hold_ready(1'b1, $urandom_range(10, 60));
                    1: hold_ready(1'b0, $urandom_range(1, 12));
                    2:
                    begin
                        n = $urandom_range(10, 40);
                        repeat (n) hold_ready(1'($urandom_range(0, 1)), 1);
                    end
                    default:
                    begin
                        n = $urandom_range(1, 10);
                        repeat (n)
                        begin
                            hold_ready(1'b1, 1);
                            hold_ready(1'b0, 1);
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_reply(owner_id, status);
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int     sent;
        int     len;
        phase_t kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(hrol_pkg::MODE_LOOKUP, '0, 8'd0);
        send_item(hrol_pkg::MODE_NEXT, POINT_MAX, 8'd0);
        send_item(hrol_pkg::MODE_PREV, POINT_HALF, 8'd0);
        send_item(hrol_pkg::MODE_REMOVE, '0, 8'd5);
        send_item(MODE_SPARE_LO, POINT_HALF, 8'd9);
        send_item(MODE_SPARE_LO + 3'd1, '0, 8'd255);
        send_item(MODE_SPARE_HI, POINT_MAX, 8'd0);
        send_item(hrol_pkg::MODE_INSERT, '0, 8'd0);
        send_item(hrol_pkg::MODE_INSERT, POINT_MAX, 8'd255);
        send_item(hrol_pkg::MODE_INSERT, 64'd100, 8'd0);
        send_item(hrol_pkg::MODE_INSERT, POINT_HALF, 8'd17);
        send_item(hrol_pkg::MODE_INSERT, POINT_MAX, 8'd42);
        send_item(hrol_pkg::MODE_LOOKUP, '0, 8'd0);
        send_item(hrol_pkg::MODE_LOOKUP, POINT_MAX, 8'd0);
        send_item(hrol_pkg::MODE_LOOKUP, POINT_HALF + 64'd1, 8'd0);
        send_item(hrol_pkg::MODE_NEXT, POINT_MAX, 8'd0);
        send_item(hrol_pkg::MODE_PREV, '0, 8'd0);
        send_item(hrol_pkg::MODE_PREV, 64'd1, 8'd0);
        send_item(hrol_pkg::MODE_NEXT, POINT_HALF, 8'd0);
        send_item(hrol_pkg::MODE_REMOVE, '0, 8'd255);
        send_item(hrol_pkg::MODE_REMOVE, '0, 8'd255);
        send_item(hrol_pkg::MODE_INSERT, POINT_ALT, 8'd255);
        send_item(hrol_pkg::MODE_REMOVE, '0, 8'd0);
        send_item(hrol_pkg::MODE_LOOKUP, '0, 8'd0);
        send_item(hrol_pkg::MODE_PREV, POINT_ALT, 8'd0);
        wait_drained();

        sent = 0;
        kind = PHASE_FILL;
        len = 200;
        while (sent < ITEM_TARGET)
        begin
            if (len > ITEM_TARGET - sent)
            begin
                len = ITEM_TARGET - sent;
            end
            run_phase(kind, len);
            sent += len;
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
            end
            kind = phase_t'($urandom_range(0, 3));
            len = $urandom_range(60, 200);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/hrol_pkg.sv
hw/rtl/hrol_cell.sv
hw/rtl/hash_ring_owner_lookup.sv
tb/sv/testbench.sv
